@@ rtl/dual_cpu_mailbox_fifo_macros.svh @@
// -----------------------------------------------------------------------------
// Mailbox FIFO assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// -----------------------------------------------------------------------------
`ifndef DUAL_CPU_MAILBOX_FIFO_MACROS_SVH
`define DUAL_CPU_MAILBOX_FIFO_MACROS_SVH

`ifndef SYNTHESIS
`define DCMF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mailbox assertion failed");
`define DCMF_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mailbox assertion failed");
`else
`define DCMF_ASSERT_IMP(label, clk, rst, ante, cons)
`define DCMF_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/dcmf_pkg.sv @@
// -----------------------------------------------------------------------------
// dcmf_pkg
// Shared types and constants of the dual-CPU mailbox FIFO.
// -----------------------------------------------------------------------------
package dcmf_pkg;

  localparam int FIFO_DEPTH_DEF = 16;

  // access opcodes
  localparam logic [2:0] OP_WR_SYNC = 3'd0;
  localparam logic [2:0] OP_WR_CTRL = 3'd1;
  localparam logic [2:0] OP_PUSH    = 3'd2;
  localparam logic [2:0] OP_POP     = 3'd3;
  localparam logic [2:0] OP_RD_SYNC = 3'd4;
  localparam logic [2:0] OP_RD_CTRL = 3'd5;

  // sync register bits
  localparam int SYNC_NIB_LSB  = 8;
  localparam int SYNC_TRIG_BIT = 13;
  localparam int SYNC_IE_BIT   = 14;

  // control register bits
  localparam int CTL_SEND_EMPTY = 0;
  localparam int CTL_SEND_FULL  = 1;
  localparam int CTL_SE_IE      = 2;
  localparam int CTL_CLEAR      = 3;
  localparam int CTL_RECV_EMPTY = 8;
  localparam int CTL_RECV_FULL  = 9;
  localparam int CTL_RE_IE      = 10;
  localparam int CTL_ERROR      = 14;
  localparam int CTL_ENABLE     = 15;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        side;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_side;
    logic        irq_sync;
    logic        irq_send_empty;
    logic        irq_recv_not_empty;
  } rsp_t;

  // sequencer -> datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  // datapath -> sequencer
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

@@ rtl/dcmf_ctrl.sv @@
// -----------------------------------------------------------------------------
// dcmf_ctrl
// Sequencer: takes a request, then runs it once the response register is free.
// -----------------------------------------------------------------------------
module dcmf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  dcmf_pkg::stat_t stat,
  output dcmf_pkg::cmd_t  cmd
);
  import dcmf_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.out_free) begin
          cmd.execute = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign req_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/dcmf_dp.sv @@
// -----------------------------------------------------------------------------
// dcmf_dp
// Datapath: per-side registers, shared FIFO word memory, response register.
// -----------------------------------------------------------------------------
module dcmf_dp #(
  parameter int FIFO_DEPTH = dcmf_pkg::FIFO_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  dcmf_pkg::req_t  req,
  input  dcmf_pkg::cmd_t  cmd,
  output dcmf_pkg::stat_t stat,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output dcmf_pkg::rsp_t  rsp
);
  import dcmf_pkg::*;

  localparam int HW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int MW = $clog2(2 * FIFO_DEPTH);
  localparam int MD = 2 * FIFO_DEPTH;

  // per-side state
  logic [3:0]    nibble [2];
  logic          sync_ie [2];
  logic [CW-1:0] count [2];
  logic [HW-1:0] head [2];
  logic          en [2];
  logic          se_ie [2];
  logic          re_ie [2];
  logic          err [2];
  logic [31:0]   latch [2];

  logic [3:0]    nibble_next [2];
  logic          sync_ie_next [2];
  logic [CW-1:0] count_next [2];
  logic [HW-1:0] head_next [2];
  logic          en_next [2];
  logic          se_ie_next [2];
  logic          re_ie_next [2];
  logic          err_next [2];
  logic [31:0]   latch_next [2];

  logic [31:0] mem [MD];
  logic [31:0] rdata;
  logic [MW-1:0] raddr;
  logic [MW-1:0] waddr;
  logic          push_we;

  // captured request
  logic [2:0]  op;
  logic        s;
  logic [31:0] d;
  logic        p;

  logic [SW-1:0] tail_sum;
  logic [HW-1:0] tail;
  logic [HW-1:0] head_adv;
  logic          clr_empty;
  rsp_t          rsp_next;

  assign p = ~s;

  // head of the partner's FIFO is read at capture, result used at execute
  assign raddr = req.side ? MW'(head[0]) : (MW'(FIFO_DEPTH) + MW'(head[1]));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rdata <= mem[raddr];
      op    <= req.opcode;
      s     <= req.side;
      d     <= req.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && push_we) begin
      mem[waddr] <= d;
    end
  end

  // write slot = (head + count) mod depth, sum stays below twice the depth
  assign tail_sum = SW'(head[s]) + SW'(count[s]);
  assign tail     = (tail_sum >= SW'(FIFO_DEPTH)) ? HW'(tail_sum - SW'(FIFO_DEPTH))
                                                  : HW'(tail_sum);
  assign waddr    = s ? (MW'(FIFO_DEPTH) + MW'(tail)) : MW'(tail);
  assign head_adv = (head[p] == HW'(FIFO_DEPTH - 1)) ? '0 : head[p] + 1'b1;
  assign clr_empty = d[CTL_CLEAR] || (count[s] == '0);

  always_comb begin
    nibble_next  = nibble;
    sync_ie_next = sync_ie;
    count_next   = count;
    head_next    = head;
    en_next      = en;
    se_ie_next   = se_ie;
    re_ie_next   = re_ie;
    err_next     = err;
    latch_next   = latch;
    push_we      = 1'b0;
    rsp_next     = '0;
    unique case (op)
      OP_WR_SYNC: begin
        nibble_next[s]  = d[SYNC_NIB_LSB +: 4];
        sync_ie_next[s] = d[SYNC_IE_BIT];
        if (d[SYNC_TRIG_BIT] && sync_ie[p]) begin
          rsp_next.irq_sync = 1'b1;
          rsp_next.irq_side = p;
        end
      end
      OP_WR_CTRL: begin
        se_ie_next[s] = d[CTL_SE_IE];
        re_ie_next[s] = d[CTL_RE_IE];
        en_next[s]    = d[CTL_ENABLE];
        rsp_next.irq_side = s;
        if (d[CTL_CLEAR]) begin
          count_next[s] = '0;
          head_next[s]  = '0;
          if (d[CTL_SE_IE]) rsp_next.irq_send_empty = 1'b1;
        end
        if (!se_ie[s] && d[CTL_SE_IE] && clr_empty) rsp_next.irq_send_empty = 1'b1;
        if (!re_ie[s] && d[CTL_RE_IE] && count[p] != '0) begin
          rsp_next.irq_recv_not_empty = 1'b1;
        end
        if (d[CTL_ERROR]) err_next[s] = 1'b0;
      end
      OP_PUSH: begin
        if (en[s]) begin
          if (count[s] != CW'(FIFO_DEPTH)) begin
            push_we       = 1'b1;
            count_next[s] = count[s] + 1'b1;
            if (count[s] == '0 && re_ie[p]) begin
              rsp_next.irq_recv_not_empty = 1'b1;
              rsp_next.irq_side           = p;
            end
          end else begin
            err_next[s] = 1'b1;
          end
        end
      end
      OP_POP: begin
        if (count[p] != '0) begin
          latch_next[s]      = rdata;
          rsp_next.read_data = rdata;
          if (en[s]) begin
            head_next[p]  = head_adv;
            count_next[p] = count[p] - 1'b1;
            if (count[p] == CW'(1) && se_ie[p]) begin
              rsp_next.irq_send_empty = 1'b1;
              rsp_next.irq_side       = p;
            end
          end
        end else begin
          err_next[s]        = 1'b1;
          rsp_next.read_data = latch[s];
        end
      end
      OP_RD_SYNC: begin
        rsp_next.read_data = {17'b0, sync_ie[s], 2'b0, nibble[s], 4'b0, nibble[p]};
      end
      OP_RD_CTRL: begin
        rsp_next.read_data[CTL_SEND_EMPTY] = (count[s] == '0);
        rsp_next.read_data[CTL_SEND_FULL]  = (count[s] == CW'(FIFO_DEPTH));
        rsp_next.read_data[CTL_SE_IE]      = se_ie[s];
        rsp_next.read_data[CTL_RECV_EMPTY] = (count[p] == '0);
        rsp_next.read_data[CTL_RECV_FULL]  = (count[p] == CW'(FIFO_DEPTH));
        rsp_next.read_data[CTL_RE_IE]      = re_ie[s];
        rsp_next.read_data[CTL_ERROR]      = err[s];
        rsp_next.read_data[CTL_ENABLE]     = en[s];
      end
      default: ;
    endcase
    // no pulse -> target side reads zero
    if (!(rsp_next.irq_sync || rsp_next.irq_send_empty || rsp_next.irq_recv_not_empty)) begin
      rsp_next.irq_side = 1'b0;
    end
  end

  assign stat.out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        nibble[i]  <= '0;
        sync_ie[i] <= 1'b0;
        count[i]   <= '0;
        head[i]    <= '0;
        en[i]      <= 1'b0;
        se_ie[i]   <= 1'b0;
        re_ie[i]   <= 1'b0;
        err[i]     <= 1'b0;
        latch[i]   <= '0;
      end
    end else if (cmd.execute) begin
      nibble  <= nibble_next;
      sync_ie <= sync_ie_next;
      count   <= count_next;
      head    <= head_next;
      en      <= en_next;
      se_ie   <= se_ie_next;
      re_ie   <= re_ie_next;
      err     <= err_next;
      latch   <= latch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.execute) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ rtl/dual_cpu_mailbox_fifo.sv @@
// Requests: a request is taken in the capture step and run in the execute step; the
//   block takes no new request until the last one has run. The FIFO word memory read
//   is registered, so the capture step reads the head and the execute step applies the access.
// A stalled response holds the next request in the execute step only.
// Reset (rst, synchronous): all side registers, counts and latches clear; FIFO words
//   are not cleared and are readable once pushed.
// -----------------------------------------------------------------------------
// dual_cpu_mailbox_fifo
// Two-sided inter-processor mailbox with per-side send FIFOs and interrupts.
// -----------------------------------------------------------------------------
`include "dual_cpu_mailbox_fifo_macros.svh"

module dual_cpu_mailbox_fifo #(
  parameter int FIFO_DEPTH = dcmf_pkg::FIFO_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  dcmf_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output dcmf_pkg::rsp_t rsp
);
  import dcmf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  dcmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  dcmf_dp #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  `DCMF_ASSERT_NXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall)
  `DCMF_ASSERT_IMP(a_side_zero_no_irq, clk, rst, rsp_valid && !rsp.irq_sync && !rsp.irq_send_empty && !rsp.irq_recv_not_empty, !rsp.irq_side)
  `DCMF_ASSERT_IMP(a_sync_alone, clk, rst, rsp_valid && rsp.irq_sync, !rsp.irq_send_empty && !rsp.irq_recv_not_empty)

endmodule

@@ dv/dual_cpu_mailbox_fifo_tb.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// dual_cpu_mailbox_fifo_tb
// Drives bus accesses from both sides into the mailbox, predicts every response
// with a behavioral mailbox model and compares the responses field by field.
// A directed opening is followed by random push/pop bursts, control and sync
// writes, register reads and some noise, with random idling on both sides.
// -----------------------------------------------------------------------------
module dual_cpu_mailbox_fifo_tb;
  import dcmf_pkg::*;

  localparam int DEPTH       = FIFO_DEPTH_DEF;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int NUM_ITEMS   = 1100;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  // opcodes the block decodes as no-ops
  localparam logic [2:0] OP_NOP_A = 3'd6;
  localparam logic [2:0] OP_NOP_B = 3'd7;

  typedef struct {
    req_t r;
    bit   drain;  // wait for all responses before offering this request
  } access_t;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  dual_cpu_mailbox_fifo uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // mailbox state, mirrored per side
  logic [3:0]       sync_nib   [2] = '{default: '0};
  logic             sync_ie    [2] = '{default: '0};
  logic [31:0]      words      [2*DEPTH];
  logic [PTR_W:0]   cnt        [2] = '{default: '0};
  logic [PTR_W-1:0] head       [2] = '{default: '0};
  logic             fifo_on    [2] = '{default: '0};
  logic             se_ie      [2] = '{default: '0};
  logic             re_ie      [2] = '{default: '0};
  logic             err_flag   [2] = '{default: '0};
  logic [31:0]      rx_latch   [2] = '{default: '0};

  access_t pending[$];
  rsp_t    expected_rsp[$];
  access_t nxt;
  rsp_t    want;
  bit      drain_next = 0;
  logic    req_fire = 1'b0;
  int      n_accepted = 0;
  int      err_count = 0;
  int      cyc = 0;
  int      hold_left = 0;
  int      hold_at = 300;
  logic    calm;

  assign calm = (cyc >= 1500 && cyc < 2500);

  function automatic rsp_t mailbox_step(req_t r);
    rsp_t        o;
    logic        s, p;
    logic [31:0] d;
    logic        old_se, old_re;
    int          slot;
    o = '0;
    s = r.side;
    p = ~r.side;
    d = r.write_data;
    case (r.opcode)
      OP_WR_SYNC: begin
        sync_nib[s] = d[SYNC_NIB_LSB +: 4];
        sync_ie[s]  = d[SYNC_IE_BIT];
        if (d[SYNC_TRIG_BIT] && sync_ie[p]) begin
          o.irq_sync = 1'b1;
          o.irq_side = p;
        end
      end
      OP_WR_CTRL: begin
        old_se     = se_ie[s];
        old_re     = re_ie[s];
        se_ie[s]   = d[CTL_SE_IE];
        re_ie[s]   = d[CTL_RE_IE];
        fifo_on[s] = d[CTL_ENABLE];
        o.irq_side = s;
        if (d[CTL_CLEAR]) begin
          cnt[s]  = '0;
          head[s] = '0;
          if (se_ie[s]) o.irq_send_empty = 1'b1;
        end
        if (!old_se && se_ie[s] && cnt[s] == 0) o.irq_send_empty = 1'b1;
        if (!old_re && re_ie[s] && cnt[p] != 0) o.irq_recv_not_empty = 1'b1;
        if (d[CTL_ERROR]) err_flag[s] = 1'b0;
      end
      OP_PUSH: begin
        if (fifo_on[s]) begin
          if (cnt[s] < DEPTH) begin
            slot = (int'(head[s]) + int'(cnt[s])) % DEPTH;
            words[int'(s) * DEPTH + slot] = d;
            cnt[s] = cnt[s] + 1'b1;
            if (cnt[s] == 1 && re_ie[p]) begin
              o.irq_recv_not_empty = 1'b1;
              o.irq_side = p;
            end
          end else begin
            err_flag[s] = 1'b1;
          end
        end
      end
      OP_POP: begin
        if (cnt[p] != 0) begin
          rx_latch[s] = words[int'(p) * DEPTH + int'(head[p])];
          if (fifo_on[s]) begin
            head[p] = PTR_W'((int'(head[p]) + 1) % DEPTH);
            cnt[p]  = cnt[p] - 1'b1;
            if (cnt[p] == 0 && se_ie[p]) begin
              o.irq_send_empty = 1'b1;
              o.irq_side = p;
            end
          end
        end else begin
          err_flag[s] = 1'b1;
        end
        o.read_data = rx_latch[s];
      end
      OP_RD_SYNC: begin
        o.read_data[3:0]                 = sync_nib[p];
        o.read_data[SYNC_NIB_LSB +: 4]   = sync_nib[s];
        o.read_data[SYNC_IE_BIT]         = sync_ie[s];
      end
      OP_RD_CTRL: begin
        o.read_data[CTL_SEND_EMPTY] = (cnt[s] == 0);
        o.read_data[CTL_SEND_FULL]  = (cnt[s] >= DEPTH);
        o.read_data[CTL_SE_IE]      = se_ie[s];
        o.read_data[CTL_RECV_EMPTY] = (cnt[p] == 0);
        o.read_data[CTL_RECV_FULL]  = (cnt[p] >= DEPTH);
        o.read_data[CTL_RE_IE]      = re_ie[s];
        o.read_data[CTL_ERROR]      = err_flag[s];
        o.read_data[CTL_ENABLE]     = fifo_on[s];
      end
      default: ;
    endcase
    if (!(o.irq_sync || o.irq_send_empty || o.irq_recv_not_empty)) o.irq_side = 1'b0;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    err_count++;
    $display("[%0t] mismatch %s: got %h, expected %h", $realtime, what, got, exp_val);
  endtask

  task automatic add_access(logic [2:0] op, logic side, logic [31:0] data);
    access_t a;
    a.r.opcode     = op;
    a.r.side       = side;
    a.r.write_data = data;
    a.drain        = drain_next;
    drain_next     = 0;
    pending.push_back(a);
  endtask

  function automatic logic [31:0] ctrl_word();
    logic [31:0] d;
    d = $urandom;
    d[CTL_ENABLE] = ($urandom_range(0, 9) != 0);
    d[CTL_CLEAR]  = ($urandom_range(0, 11) == 0);
    return d;
  endfunction

  task automatic build_random();
    int  pick, len, last_mark;
    logic s;
    last_mark = 0;
    // one guaranteed overflow burst up front
    drain_next = 1;
    for (int i = 0; i < DEPTH + 2; i++) add_access(OP_PUSH, 1'b0, $urandom);
    add_access(OP_RD_CTRL, 1'b0, $urandom);
    add_access(OP_RD_CTRL, 1'b1, $urandom);
    while (pending.size() < NUM_ITEMS) begin
      if (pending.size() / 200 != last_mark) begin
        last_mark  = pending.size() / 200;
        drain_next = 1;
      end
      pick = $urandom_range(0, 99);
      s    = 1'($urandom_range(0, 1));
      if (pick < 40) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(DEPTH, DEPTH + 4)
                                          : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) add_access(OP_PUSH, s, $urandom);
      end else if (pick < 70) begin
        len = $urandom_range(1, DEPTH + 2);
        for (int i = 0; i < len; i++) add_access(OP_POP, s, $urandom);
      end else if (pick < 80) begin
        add_access(OP_WR_CTRL, s, ctrl_word());
      end else if (pick < 88) begin
        add_access(OP_WR_SYNC, s, $urandom);
      end else if (pick < 96) begin
        add_access($urandom_range(0, 1) ? OP_RD_CTRL : OP_RD_SYNC, s, $urandom);
      end else begin
        add_access(3'($urandom_range(0, 7)), s, $urandom);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (pending.size() != 0 && !(pending[0].drain && expected_rsp.size() != 0)
          && !(!calm && $urandom_range(0, 99) < 30)) begin
        nxt = pending.pop_front();
        req       <= nxt.r;
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response stall, with long hold-offs that back the block up
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (n_accepted >= hold_at) begin
      rsp_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_at   <= hold_at + 450;
    end else begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 30);
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("unexpected response", rsp.read_data, '0);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.read_data !== want.read_data)
            report_mismatch("read_data", rsp.read_data, want.read_data);
          if (rsp.irq_side !== want.irq_side)
            report_mismatch("irq_side", rsp.irq_side, want.irq_side);
          if (rsp.irq_sync !== want.irq_sync)
            report_mismatch("irq_sync", rsp.irq_sync, want.irq_sync);
          if (rsp.irq_send_empty !== want.irq_send_empty)
            report_mismatch("irq_send_empty", rsp.irq_send_empty, want.irq_send_empty);
          if (rsp.irq_recv_not_empty !== want.irq_recv_not_empty)
            report_mismatch("irq_recv_not_empty", rsp.irq_recv_not_empty,
                            want.irq_recv_not_empty);
        end
      end
      req_fire <= req_valid && !req_stall;
      if (req_valid && !req_stall) begin
        expected_rsp.push_back(mailbox_step(req));
        n_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    // directed opening: reset images, errors while disabled, pulses of each kind
    add_access(OP_RD_CTRL, 1'b0, 32'h0);
    add_access(OP_RD_SYNC, 1'b1, 32'hFFFF_FFFF);
    add_access(OP_POP,     1'b0, 32'h0);          // empty pop while disabled
    add_access(OP_PUSH,    1'b0, 32'hDEAD_BEEF);  // dropped, FIFO disabled
    add_access(OP_RD_CTRL, 1'b0, 32'h0);
    add_access(OP_WR_SYNC, 1'b1, 32'h0000_4F00);
    add_access(OP_WR_SYNC, 1'b0, 32'hFFFF_FFFF);  // trigger to side 1
    add_access(OP_RD_SYNC, 1'b0, 32'h0);
    add_access(OP_RD_SYNC, 1'b1, 32'h0);
    add_access(OP_WR_CTRL, 1'b1, 32'h0000_8404);
    add_access(OP_WR_CTRL, 1'b0, 32'h0000_C004);  // also clears the error
    add_access(OP_PUSH,    1'b0, 32'hFFFF_FFFF);  // first word, recv pulse
    add_access(OP_PUSH,    1'b0, 32'h0000_0000);
    add_access(OP_RD_CTRL, 1'b1, 32'h0);
    add_access(OP_WR_CTRL, 1'b1, 32'h0000_8000);
    add_access(OP_WR_CTRL, 1'b1, 32'h0000_8404);  // enables rise with data waiting
    add_access(OP_WR_CTRL, 1'b1, 32'h0000_0404);  // disabled: pops only peek
    add_access(OP_POP,     1'b1, 32'h0);
    add_access(OP_POP,     1'b1, 32'h0);
    add_access(OP_WR_CTRL, 1'b1, 32'h0000_8404);
    add_access(OP_POP,     1'b1, 32'h0);
    add_access(OP_POP,     1'b1, 32'h0);          // empties side 0, send-empty pulse
    add_access(OP_POP,     1'b1, 32'h0);          // underflow returns latched word
    add_access(OP_WR_CTRL, 1'b0, 32'hFFFF_FFFF);  // clear with enable set
    add_access(OP_NOP_A,   1'b1, 32'hFFFF_FFFF);
    add_access(OP_NOP_B,   1'b0, 32'hFFFF_FFFF);
    add_access(OP_WR_SYNC, 1'b1, 32'h0000_2000);  // trigger to side 0
    build_random();

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending.size() != 0 || req_valid) @(posedge clk);
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
